### hw/rtl/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  localparam int KindW   = 3;
  localparam int PosW    = 5;
  localparam int DataW   = 32;
  localparam int StatusW = 2;
  localparam int LenW    = 5;

  localparam logic [KindW-1:0] KIND_INSERT  = 3'd0;
  localparam logic [KindW-1:0] KIND_REMOVE  = 3'd1;
  localparam logic [KindW-1:0] KIND_READ    = 3'd2;
  localparam logic [KindW-1:0] KIND_REPLACE = 3'd3;
  localparam logic [KindW-1:0] KIND_CLEAR   = 3'd4;

  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_BADPOS = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [StatusW-1:0]      status;
    logic [LenW-1:0]         list_length;
    logic                    is_empty;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/pls_store.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_store
  import pls_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output logic signed [DataW-1:0]      rd_data,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic signed [DataW-1:0] wr_data
);

  logic signed [DataW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pls_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl
  import pls_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [KindW-1:0]        kind,
  input  wire logic [PosW-1:0]         position,
  input  wire logic signed [DataW-1:0] value,
  input  wire logic                    out_free,
  output logic                         res_valid,
  output result_t                      res,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr,
  input  wire logic signed [DataW-1:0] rd_data,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic signed [DataW-1:0]      wr_data
);

  localparam int CMPW = (CW > PosW) ? CW + 1 : PosW + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MOVE_RD = 3'd1;
  localparam logic [2:0] S_MOVE_WR = 3'd2;
  localparam logic [2:0] S_PUT     = 3'd3;
  localparam logic [2:0] S_READ    = 3'd4;
  localparam logic [2:0] S_FINISH  = 3'd5;

  logic [2:0]              state;
  logic [CW-1:0]           count;
  logic [AW-1:0]           idx;
  logic [AW-1:0]           end_idx;
  logic                    dir;       // 0: move toward higher slots (insert)
  logic signed [DataW-1:0] op_val;
  logic [StatusW-1:0]      status_r;
  logic                    rd_ok;

  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] cnt_w;
  logic            pos_nz;
  logic            in_list;
  logic            ins_ok;
  logic            full;
  logic [AW-1:0]   tgt;
  logic [AW-1:0]   cnt_a;
  logic [AW-1:0]   cnt_m1;
  logic [AW-1:0]   src;
  logic            accept;

  assign pos_w   = CMPW'(position);
  assign cnt_w   = CMPW'(count);
  assign pos_nz  = (pos_w != '0);
  assign in_list = pos_nz && (pos_w <= cnt_w);
  assign ins_ok  = pos_nz && (pos_w <= cnt_w + CMPW'(1));
  assign full    = (cnt_w == CMPW'(DEPTH));
  assign tgt     = AW'(pos_w - CMPW'(1));
  assign cnt_a   = AW'(cnt_w);
  assign cnt_m1  = AW'(cnt_w - CMPW'(1));

  // shared index unit: next slot in the current shift direction
  assign src = dir ? (idx + AW'(1)) : (idx - AW'(1));

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign rd_en   = (state == S_MOVE_RD) || (state == S_READ);
  assign rd_addr = (state == S_READ) ? end_idx : src;
  assign wr_en   = (state == S_MOVE_WR) || (state == S_PUT);
  assign wr_addr = (state == S_PUT) ? end_idx : idx;
  assign wr_data = (state == S_PUT) ? op_val : rd_data;

  assign res_valid       = (state == S_FINISH);
  assign res.read_value  = rd_ok ? rd_data : '0;
  assign res.status      = status_r;
  assign res.list_length = cnt_w[LenW-1:0];
  assign res.is_empty    = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            status_r <= ST_OK;
            rd_ok    <= 1'b0;
            op_val   <= value;
            state    <= S_FINISH;
            case (kind)
              KIND_INSERT: begin
                if (!ins_ok) begin
                  status_r <= ST_BADPOS;
                end else if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  idx     <= cnt_a;
                  end_idx <= tgt;
                  dir     <= 1'b0;
                  count   <= count + CW'(1);
                  state   <= (cnt_a == tgt) ? S_PUT : S_MOVE_RD;
                end
              end
              KIND_REMOVE: begin
                if (!in_list) begin
                  status_r <= ST_BADPOS;
                end else begin
                  idx     <= tgt;
                  end_idx <= cnt_m1;
                  dir     <= 1'b1;
                  count   <= count - CW'(1);
                  state   <= (tgt == cnt_m1) ? S_FINISH : S_MOVE_RD;
                end
              end
              KIND_READ: begin
                if (!in_list) begin
                  status_r <= ST_BADPOS;
                end else begin
                  end_idx <= tgt;
                  rd_ok   <= 1'b1;
                  state   <= S_READ;
                end
              end
              KIND_REPLACE: begin
                if (!in_list) begin
                  status_r <= ST_BADPOS;
                end else begin
                  end_idx <= tgt;
                  state   <= S_PUT;
                end
              end
              KIND_CLEAR: begin
                count <= '0;
              end
              default: begin
                status_r <= ST_BADPOS;
              end
            endcase
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          idx <= src;
          if (src == end_idx) begin
            state <= dir ? S_FINISH : S_PUT;
          end else begin
            state <= S_MOVE_RD;
          end
        end
        S_PUT: begin
          state <= S_FINISH;
        end
        S_READ: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/positional_list_store_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded positional list of up to DEPTH signed 32-bit entries.
// Input channel (in_valid/in_stall): kind, position (1-based), value.
// Output channel (out_valid/out_stall): read_value, status, list_length,
// is_empty; exactly one result transaction per input transaction, in order.
// One request is handled at a time; in_stall is high while the sequencer
// works. Entries are moved one slot at a time, each by a read state and a
// write state, through a single-port read, single-port write store, driven
// by one shared index unit. Insert moves the entries at and after the
// position up from the end, then writes the new value; remove moves the
// later entries down; read and replace do one store access; clear and
// rejected requests go straight to the result. A new request is taken only
// once the sequencer is back in idle.
// The result sits in an output register; the next request is accepted
// while it waits. If the receiver stalls, the following result is held in
// the sequencer and no further request is taken until the register frees.
// Reset (rst, synchronous) empties the list and drops any pending result;
// the entry storage itself is not cleared.
module positional_list_store_top
  import pls_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [KindW-1:0]        kind,
  input  wire logic [PosW-1:0]         position,
  input  wire logic signed [DataW-1:0] value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [DataW-1:0]      read_value,
  output logic [StatusW-1:0]           status,
  output logic [LenW-1:0]              list_length,
  output logic                         is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                    out_free;
  logic                    res_valid;
  result_t                 res;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic signed [DataW-1:0] rd_data;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [DataW-1:0] wr_data;

  assign out_free = !out_valid || !out_stall;

  pls_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .position  (position),
    .value     (value),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  pls_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      read_value  <= res.read_value;
      status      <= res.status;
      list_length <= res.list_length;
      is_empty    <= res.is_empty;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pls_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_checker
  import pls_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [DataW-1:0] read_value,
  input wire logic [StatusW-1:0]      status,
  input wire logic [LenW-1:0]         list_length,
  input wire logic                    is_empty
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status)
      && $stable(list_length) && $stable(is_empty))
    else $error("stalled result changed");

  // no result without a request: in the cycle after reset nothing is pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // every accepted request makes in_stall high in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // only a good read carries data
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (read_value == '0))
    else $error("nonzero read_value on failed request");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (list_length == '0) && (status != ST_FULL))
    else $error("empty flag disagrees with length or status");

endmodule

bind positional_list_store_top pls_checker u_pls_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .read_value  (read_value),
  .status      (status),
  .list_length (list_length),
  .is_empty    (is_empty)
);

`default_nettype wire

### sim/positional_list_store_top_test.sv
`timescale 1ns / 1ps

module positional_list_store_top_test;
  import pls_pkg::*;

  localparam int ListDepth = 16;
  localparam int RandomItems = 2000;
  localparam int CalmTail = 300;
  localparam int DrainCycles = 40;
  localparam int NumRows = 25;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] val;
    logic [4:0]              reps;
    logic                    typed;
    result_t                 want;
  } step_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [KindW-1:0]        kind = '0;
  logic [PosW-1:0]         position = '0;
  logic signed [DataW-1:0] value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [DataW-1:0] read_value;
  logic [StatusW-1:0]      status;
  logic [LenW-1:0]         list_length;
  logic                    is_empty;

  // shadow copy of the list
  logic signed [DataW-1:0] list_model [ListDepth];
  int                      list_count = 0;

  result_t   pending_results [$];
  step_row_t script [NumRows];
  bit        no_idle = 1'b0;
  int        hold_left = 0;
  int        issued_count = 0;
  int        checked_count = 0;
  int        mismatch_count = 0;
  int        status_seen [3] = '{0, 0, 0};
  int        longest_list = 0;

  positional_list_store_top #(
    .DEPTH(ListDepth)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .status     (status),
    .list_length(list_length),
    .is_empty   (is_empty)
  );

  always #5 clk = ~clk;

  function automatic result_t apply_request(input logic [KindW-1:0] k,
                                            input logic [PosW-1:0] p,
                                            input logic signed [DataW-1:0] v);
    result_t r;
    int      pi;
    int      idx;
    bit      in_list;
    r = '0;
    r.status = ST_OK;
    pi = int'(p);
    in_list = (pi >= 1) && (pi <= list_count);
    case (k)
      KIND_INSERT: begin
        if (pi < 1 || pi > list_count + 1) begin
          r.status = ST_BADPOS;
        end else if (list_count >= ListDepth) begin
          r.status = ST_FULL;
        end else begin
          for (idx = list_count; idx > pi - 1; idx--) list_model[idx] = list_model[idx-1];
          list_model[pi-1] = v;
          list_count++;
        end
      end
      KIND_REMOVE: begin
        if (!in_list) begin
          r.status = ST_BADPOS;
        end else begin
          for (idx = pi - 1; idx + 1 < list_count; idx++) list_model[idx] = list_model[idx+1];
          list_count--;
        end
      end
      KIND_READ: begin
        if (!in_list) r.status = ST_BADPOS;
        else r.read_value = list_model[pi-1];
      end
      KIND_REPLACE: begin
        if (!in_list) r.status = ST_BADPOS;
        else list_model[pi-1] = v;
      end
      KIND_CLEAR: begin
        list_count = 0;
      end
      default: begin
        r.status = ST_BADPOS;
      end
    endcase
    r.list_length = LenW'(list_count);
    r.is_empty = (list_count == 0);
    return r;
  endfunction

  // Caller is at a falling edge; returns at a falling edge.
  task automatic issue(input logic [KindW-1:0] k, input logic [PosW-1:0] p,
                       input logic signed [DataW-1:0] v, input bit typed,
                       input result_t want);
    result_t predicted;
    kind = k;
    position = p;
    value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(k, p, v);
    pending_results.push_back(typed ? want : predicted);
    issued_count++;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  function automatic logic [KindW-1:0] pick_kind(input bit growing);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return KindW'($urandom_range(5, 7));
    if (roll == 2) return KIND_CLEAR;
    if (growing) begin
      if (roll < 55) return KIND_INSERT;
      if (roll < 70) return KIND_REMOVE;
      if (roll < 85) return KIND_READ;
      return KIND_REPLACE;
    end
    if (roll < 25) return KIND_INSERT;
    if (roll < 60) return KIND_REMOVE;
    if (roll < 80) return KIND_READ;
    return KIND_REPLACE;
  endfunction

  function automatic logic [PosW-1:0] pick_position(input logic [KindW-1:0] k);
    if ($urandom_range(0, 4) == 0) return PosW'($urandom_range(0, 31));
    if (k == KIND_INSERT) return PosW'($urandom_range(1, list_count + 1));
    if (list_count == 0) return PosW'($urandom_range(0, 31));
    return PosW'($urandom_range(1, list_count));
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (rst || no_idle) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      hold_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{read_value, status, list_length, is_empty};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result: rd=%0d st=%0d len=%0d empty=%0b", $realtime,
                   got.read_value, got.status, got.list_length, got.is_empty);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got.read_value !== want.read_value || got.status !== want.status ||
            got.list_length !== want.list_length || got.is_empty !== want.is_empty) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] mismatch: expected rd=%0d st=%0d len=%0d empty=%0b, got rd=%0d st=%0d len=%0d empty=%0b",
                     $realtime, want.read_value, want.status, want.list_length, want.is_empty,
                     got.read_value, got.status, got.list_length, got.is_empty);
        end
        if (got.status <= ST_FULL) status_seen[got.status]++;
        if (int'(got.list_length) > longest_list) longest_list = int'(got.list_length);
      end
    end
  end

  initial begin
    step_row_t        row;
    int               i;
    int               r;
    int               phase_left;
    bit               growing;
    logic [KindW-1:0] k;
    result_t          none;

    none = '0;
    // empty list: only insert at position 1 succeeds; then directed edits and reads
    script[0]  = '{KIND_READ,    5'd1,  32'sd0,          5'd1,  1'b1, '{32'sd0, ST_BADPOS, 5'd0, 1'b1}};
    script[1]  = '{KIND_REMOVE,  5'd0,  32'sd0,          5'd1,  1'b1, '{32'sd0, ST_BADPOS, 5'd0, 1'b1}};
    script[2]  = '{KIND_REPLACE, 5'd1,  32'sd5,          5'd1,  1'b1, '{32'sd0, ST_BADPOS, 5'd0, 1'b1}};
    script[3]  = '{KIND_INSERT,  5'd0,  32'sd9,          5'd1,  1'b1, '{32'sd0, ST_BADPOS, 5'd0, 1'b1}};
    script[4]  = '{KIND_INSERT,  5'd2,  32'sd9,          5'd1,  1'b1, '{32'sd0, ST_BADPOS, 5'd0, 1'b1}};
    script[5]  = '{KIND_INSERT,  5'd1,  32'sh8000_0000,  5'd1,  1'b1, '{32'sd0, ST_OK, 5'd1, 1'b0}};
    script[6]  = '{KIND_INSERT,  5'd2,  32'sh7fff_ffff,  5'd1,  1'b1, '{32'sd0, ST_OK, 5'd2, 1'b0}};
    script[7]  = '{KIND_INSERT,  5'd1,  -32'sd1,         5'd1,  1'b1, '{32'sd0, ST_OK, 5'd3, 1'b0}};
    script[8]  = '{KIND_READ,    5'd1,  32'sd0,          5'd1,  1'b1, '{-32'sd1, ST_OK, 5'd3, 1'b0}};
    script[9]  = '{KIND_READ,    5'd3,  32'sd0,          5'd1,  1'b1, '{32'sh7fff_ffff, ST_OK, 5'd3, 1'b0}};
    script[10] = '{KIND_READ,    5'd4,  32'sd0,          5'd1,  1'b1, '{32'sd0, ST_BADPOS, 5'd3, 1'b0}};
    script[11] = '{KIND_REPLACE, 5'd2,  32'sh55aa_33cc,  5'd1,  1'b1, '{32'sd0, ST_OK, 5'd3, 1'b0}};
    script[12] = '{KIND_READ,    5'd2,  32'sd0,          5'd1,  1'b1, '{32'sh55aa_33cc, ST_OK, 5'd3, 1'b0}};
    script[13] = '{KIND_REPLACE, 5'd31, -32'sd1,         5'd1,  1'b1, '{32'sd0, ST_BADPOS, 5'd3, 1'b0}};
    script[14] = '{KIND_REMOVE,  5'd3,  32'sd0,          5'd1,  1'b1, '{32'sd0, ST_OK, 5'd2, 1'b0}};
    script[15] = '{3'd5,         5'd1,  32'sd0,          5'd1,  1'b1, '{32'sd0, ST_BADPOS, 5'd2, 1'b0}};
    script[16] = '{3'd7,         5'd31, -32'sd1,         5'd1,  1'b1, '{32'sd0, ST_BADPOS, 5'd2, 1'b0}};
    script[17] = '{KIND_REMOVE,  5'd1,  32'sd0,          5'd1,  1'b1, '{32'sd0, ST_OK, 5'd1, 1'b0}};
    script[18] = '{KIND_CLEAR,   5'd0,  32'sd0,          5'd1,  1'b1, '{32'sd0, ST_OK, 5'd0, 1'b1}};
    // fill to capacity, then push against the limit
    script[19] = '{KIND_INSERT,  5'd1,  32'sh0000_0100,  5'd16, 1'b0, none};
    script[20] = '{KIND_INSERT,  5'd17, 32'sd0,          5'd1,  1'b1, '{32'sd0, ST_FULL, 5'd16, 1'b0}};
    script[21] = '{KIND_INSERT,  5'd1,  32'sd0,          5'd1,  1'b1, '{32'sd0, ST_FULL, 5'd16, 1'b0}};
    script[22] = '{KIND_INSERT,  5'd18, 32'sd0,          5'd1,  1'b1, '{32'sd0, ST_BADPOS, 5'd16, 1'b0}};
    script[23] = '{KIND_READ,    5'd16, 32'sd0,          5'd1,  1'b0, none};
    script[24] = '{KIND_REMOVE,  5'd16, 32'sd0,          5'd1,  1'b1, '{32'sd0, ST_OK, 5'd15, 1'b0}};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < NumRows; i++) begin
      row = script[i];
      for (r = 0; r < int'(row.reps); r++)
        issue(row.kind, row.pos, row.val + r, row.typed, row.want);
    end

    // random part: alternate fill-leaning and drain-leaning stretches
    phase_left = 0;
    growing = 1'b1;
    for (i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - CalmTail) begin
        no_idle = 1'b1;
      end else if (phase_left == 0) begin
        phase_left = $urandom_range(30, 120);
        growing = ~growing;
        if (i < RandomItems - CalmTail) no_idle = ($urandom_range(0, 3) == 0);
      end
      if (phase_left != 0) phase_left--;
      k = pick_kind(growing);
      issue(k, pick_position(k), pick_value(), 1'b0, none);
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Issued %0d requests (directed and random), checked %0d results, %0d mismatches.",
             issued_count, checked_count, mismatch_count);
    $display("Status mix ok/bad-position/full: %0d/%0d/%0d, longest list %0d.",
             status_seen[0], status_seen[1], status_seen[2], longest_list);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
